// ----- rtl/core/dkc_pkg.sv -----
// Shared types, key schedule tables and permutation functions for the round key counter.
package dkc_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned CdW     = 56;
  localparam int unsigned HalfW   = 28;
  localparam int unsigned RkW     = 48;
  localparam int unsigned Rounds  = 16;
  localparam int unsigned CountW  = 5;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  typedef logic [CdW-1:0] dkc_cd_t;
  typedef logic [RkW-1:0] dkc_rk_t;

  // Queue status seen by both the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } dkc_q_stat_t;

  localparam logic [6:0] PC1_TAB [CdW] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [RkW] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Total left rotation of each half after every round.
  localparam logic [4:0] ROT_SUM [Rounds] = '{
    5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
  };

  function automatic dkc_cd_t dkc_pc1(input logic [KeyW-1:0] key);
    dkc_cd_t    cd;
    logic [5:0] idx;
    for (int i = 0; i < CdW; i++) begin
      idx = 6'(7'(KeyW) - PC1_TAB[i]);
      cd[CdW-1-i] = key[idx];
    end
    return cd;
  endfunction

  function automatic dkc_rk_t dkc_pc2(input dkc_cd_t cd);
    dkc_rk_t    rk;
    logic [5:0] idx;
    for (int i = 0; i < RkW; i++) begin
      idx = 6'(6'(CdW) - PC2_TAB[i]);
      rk[RkW-1-i] = cd[idx];
    end
    return rk;
  endfunction

  function automatic logic [HalfW-1:0] dkc_rotl(input logic [HalfW-1:0] v,
                                                input logic [4:0] n);
    logic [2*HalfW-1:0] vv;
    vv = {v, v};
    return vv[(2*HalfW-1) - n -: HalfW];
  endfunction

  function automatic dkc_rk_t dkc_round_key(input dkc_cd_t cd, input logic [4:0] n);
    dkc_cd_t rot;
    rot = {dkc_rotl(cd[CdW-1:HalfW], n), dkc_rotl(cd[HalfW-1:0], n)};
    return dkc_pc2(rot);
  endfunction

endpackage

// ----- rtl/core/dkc_front.sv -----
// Front end: takes key requests and pushes their permuted-choice-1 halves into the queue.
module dkc_front import dkc_pkg::*; (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [KeyW-1:0]     s_axis_tdata,   // [63:0] key
  input  dkc_q_stat_t         q_stat_i,
  output logic                push_o,
  output dkc_cd_t             push_cd_o
);

  assign s_axis_tready = ~q_stat_i.full;
  assign push_o        = s_axis_tvalid & ~q_stat_i.full;
  assign push_cd_o     = dkc_pc1(s_axis_tdata);

endmodule

// ----- rtl/core/dkc_fifo.sv -----
// Short queue of permuted key halves between the front and back ends.
module dkc_fifo import dkc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  dkc_cd_t     push_cd_i,
  input  logic        pop_i,
  output dkc_cd_t     pop_cd_o,
  output dkc_q_stat_t stat_o
);

  dkc_cd_t            mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_cd_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cd_i;
    end
  end

endmodule

// ----- rtl/core/dkc_back.sv -----
// Back end: expands round keys, flags first occurrences, counts them into the output register.
module dkc_back import dkc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dkc_q_stat_t       q_stat_i,
  input  dkc_cd_t           pop_cd_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata    // [4:0] distinct_count, [7:5] zero
);

  dkc_rk_t             rk [Rounds];
  logic [Rounds-1:0]   first_d, first_q;
  logic                s1_vld_q;
  logic [CountW-1:0]   cnt_d, cnt_q;
  logic                out_vld_q;
  logic                out_adv, s1_adv;

  assign out_adv = ~out_vld_q | m_axis_tready;
  assign s1_adv  = ~s1_vld_q | out_adv;
  assign pop_o   = ~q_stat_i.empty & s1_adv;

  // Each round key gets its own fixed rotation of both halves.
  always_comb begin
    for (int i = 0; i < Rounds; i++) begin
      rk[i] = dkc_round_key(pop_cd_i, ROT_SUM[i]);
    end
  end

  // Flag a round key when no earlier round key matches it.
  always_comb begin
    for (int i = 0; i < Rounds; i++) begin
      first_d[i] = 1'b1;
      for (int j = 0; j < i; j++) begin
        if (rk[j] == rk[i]) begin
          first_d[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    cnt_d = '0;
    for (int i = 0; i < Rounds; i++) begin
      cnt_d = cnt_d + CountW'(first_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_vld_q <= pop_o;
      end
      if (out_adv) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      first_q <= first_d;
    end
    if (out_adv && s1_vld_q) begin
      cnt_q <= cnt_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, cnt_q};

endmodule

// ----- rtl/core/des_distinct_round_key_count.sv -----
// Top level of the DES distinct round key counter.
// Usage:
//   A key request arrives on the slave stream (s_axis_*): tdata carries the
//   64-bit DES key, byte 0 in the top bits; parity bits are ignored.
//   Each key yields one result on the master stream (m_axis_*): tdata[4:0]
//   holds how many of the sixteen round keys differ, 1 to 16.
//   The accepting edge writes the key into the queue; its result then
//   passes the compare stage (first_q) and the count stage (cnt_q)
//   before it shows on m_axis_tvalid.
//   Throughput: one key per cycle while the receiver keeps m_axis_tready high,
//   set by the single compare stage and single count stage, each taking a key per cycle.
//   A four-entry queue sits between the key intake and the compare logic;
//   when the receiver holds m_axis_tready low, the output and compare stages
//   hold, the queue fills, and s_axis_tready drops once it is full.
//   Results leave in request order, none dropped.
//   Reset (rst_ni low, asynchronous) empties the queue and clears all
//   valid flags; no request is in flight afterwards.
module des_distinct_round_key_count import dkc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [KeyW-1:0]   s_axis_tdata,   // [63:0] key
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata    // [4:0] distinct_count, [7:5] zero
);

  dkc_q_stat_t q_stat;
  logic        push, pop;
  dkc_cd_t     push_cd, pop_cd;

  dkc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_cd_o     (push_cd)
  );

  dkc_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cd_i (push_cd),
    .pop_i     (pop),
    .pop_cd_o  (pop_cd),
    .stat_o    (q_stat)
  );

  dkc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .pop_cd_i      (pop_cd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
